// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// Shared concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_HOLDS(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_HOLDS(name, clk, rst_n, prop)
`define ASSERT_NEVER(name, clk, rst_n, cond)

`endif

`endif

// File: hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_pkg
// Types, widths and helpers shared by the sample window median block.
// ----------------------------------------------------------------------------
package swm_pkg;

  // window geometry
  localparam int WINDOW = 16;
  localparam int DATA_W = 16;
  localparam int RANK_W = 4;
  localparam int OP_W   = 2;
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_MEDIAN = 2'd2
  } op_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_SELECT,
    ST_HOLD
  } state_e;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic              load;
    logic              shift;
    logic              pick;
    logic [DATA_W-1:0] wr_data;
    logic [CNT_W-1:0]  rank;
  } cell_ctrl_t;

  // ring pointer advance with wrap at the window end
  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] n;
    n = (p == IDX_W'(WINDOW - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

endpackage

// File: hw/rtl/swm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm interfaces
// Valid/ready channels for input words, result words and rank writes.
// ----------------------------------------------------------------------------

// input channel
interface swm_in_if import swm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [DATA_W-1:0] sample;

  modport source (output valid, output operation, output sample, input ready);
  modport sink   (input valid, input operation, input sample, output ready);
endinterface

// result channel
interface swm_out_if import swm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] result_value;
  logic              window_full;
  logic              window_empty;
  logic              sample_dropped;

  modport source (output valid, output result_value, output window_full,
                  output window_empty, output sample_dropped, input ready);
  modport sink   (input valid, input result_value, input window_full,
                  input window_empty, input sample_dropped, output ready);
endinterface

// rank register write channel
interface swm_cfg_if import swm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] median_rank;

  modport source (output valid, output median_rank, input ready);
  modport sink   (input valid, input median_rank, output ready);
endinterface

// File: hw/rtl/sample_window_median_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_window_median_top
// Ring window of 16-bit samples with push, pop and k-th smallest queries.
// Push and pop return their word in the cycle after acceptance. A median
// query rotates a copy of every entry once around the row of WINDOW cells,
// each cell counting smaller and equal entries, then steps through the select
// and hold states to the result; one word is in flight at a time. The rank
// register (reset 8, saturated to WINDOW-1) is written through the cfg
// channel; the user must do so only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sample_window_median_top import swm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  swm_in_if.sink    in_i,
  swm_out_if.source out_o,
  swm_cfg_if.sink   cfg_i
);

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  wp_q, wp_d;
  logic [IDX_W-1:0]  rp_q, rp_d;
  logic              full_q, full_d;
  logic              empty_q, empty_d;
  logic [RANK_W-1:0] rank_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_vld_q, out_vld_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic              ofull_q, ofull_d;
  logic              oempty_q, oempty_d;
  logic              odrop_q, odrop_d;

  logic              slot_free;
  logic              in_acc;
  op_e               op;
  cell_ctrl_t        ctrl;
  logic              wr_en;
  logic [DATA_W-1:0] rd_data;
  logic [DATA_W-1:0] median;
  logic [CNT_W-1:0]  rank_eff;

  // handshakes
  assign slot_free   = !out_vld_q || out_o.ready;
  assign in_i.ready  = (state_q == ST_IDLE) && slot_free;
  assign in_acc      = in_i.valid && in_i.ready;
  assign op          = op_e'(in_i.operation);
  assign cfg_i.ready = 1'b1;

  // rank register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_q <= RANK_W'(8);
    end else if (cfg_i.valid && cfg_i.ready) begin
      rank_q <= cfg_i.median_rank;
    end
  end

  // saturate rank to the window
  assign rank_eff = (32'(rank_q) > 32'(WINDOW - 1)) ? CNT_W'(WINDOW - 1)
                                                    : CNT_W'(rank_q);

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && op == OP_MEDIAN) state_d = ST_COUNT;
      end
      ST_COUNT: begin
        if (cnt_q == CNT_W'(WINDOW - 1)) state_d = ST_SELECT;
      end
      ST_SELECT: begin
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // rotation step counter
  always_comb begin
    cnt_d = cnt_q;
    if (in_acc) begin
      cnt_d = '0;
    end else if (state_q == ST_COUNT) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  // row control
  always_comb begin
    ctrl.load    = in_acc && (op == OP_MEDIAN);
    ctrl.shift   = (state_q == ST_COUNT);
    ctrl.pick    = (state_q == ST_SELECT);
    ctrl.wr_data = in_i.sample;
    ctrl.rank    = rank_eff;
  end

  assign wr_en = in_acc && (op == OP_PUSH) && !full_q;

  // pointers, flags and result word
  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    full_d    = full_q;
    empty_d   = empty_q;
    out_vld_d = out_vld_q && !out_o.ready;
    res_d     = res_q;
    ofull_d   = ofull_q;
    oempty_d  = oempty_q;
    odrop_d   = odrop_q;
    if (in_acc) begin
      res_d   = '0;
      odrop_d = 1'b0;
      unique case (op)
        OP_PUSH: begin
          empty_d = 1'b0;
          if (full_q) begin
            odrop_d = 1'b1;
          end else begin
            wp_d   = next_idx(wp_q);
            full_d = (next_idx(wp_q) == rp_q);
          end
        end
        OP_POP: begin
          full_d = 1'b0;
          if (!empty_q) begin
            res_d   = rd_data;
            rp_d    = next_idx(rp_q);
            empty_d = (next_idx(rp_q) == wp_q);
          end
        end
        OP_MEDIAN: begin
          res_d = res_q;
        end
        default: begin
          res_d = '0;
        end
      endcase
      if (op != OP_MEDIAN) begin
        out_vld_d = 1'b1;
        ofull_d   = full_d;
        oempty_d  = empty_d;
      end
    end else if (state_q == ST_HOLD && slot_free) begin
      out_vld_d = 1'b1;
      res_d     = median;
      ofull_d   = full_q;
      oempty_d  = empty_q;
      odrop_d   = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      full_q    <= 1'b0;
      empty_q   <= 1'b1;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      full_q    <= full_d;
      empty_q   <= empty_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    ofull_q  <= ofull_d;
    oempty_q <= oempty_d;
    odrop_q  <= odrop_d;
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.result_value   = res_q;
  assign out_o.window_full    = ofull_q;
  assign out_o.window_empty   = oempty_q;
  assign out_o.sample_dropped = odrop_q;

  // window cells
  swm_row u_row (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .wr_en_i   (wr_en),
    .wr_idx_i  (wp_q),
    .rd_idx_i  (rp_q),
    .rd_data_o (rd_data),
    .median_o  (median)
  );

  // flag and pointer consistency
  `ASSERT_NEVER(a_full_and_empty, clk_i, rst_ni, full_q && empty_q)
  `ASSERT_HOLDS(a_full_ptr, clk_i, rst_ni, full_q |-> (wp_q == rp_q))
  `ASSERT_HOLDS(a_empty_ptr, clk_i, rst_ni, empty_q |-> (wp_q == rp_q))
  `ASSERT_HOLDS(a_pop_moves, clk_i, rst_ni, (in_acc && op == OP_POP && !empty_q) |=> (rp_q != $past(rp_q)))

endmodule

// File: hw/rtl/swm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_cell
// One window entry with a rotating probe and rank counters for selection.
// ----------------------------------------------------------------------------
module swm_cell import swm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic              wr_en_i,
  input  logic [DATA_W-1:0] trav_i,
  output logic [DATA_W-1:0] trav_o,
  output logic [DATA_W-1:0] value_o,
  output logic [DATA_W-1:0] pick_o
);

  logic [DATA_W-1:0] value_q, value_d;
  logic [DATA_W-1:0] trav_q, trav_d;
  logic [CNT_W-1:0]  below_q, below_d;
  logic [CNT_W-1:0]  same_q, same_d;
  logic [DATA_W-1:0] pick_q, pick_d;
  logic [CNT_W:0]    upper;
  logic              hit;

  // stored entry, written on push
  always_comb begin
    value_d = wr_en_i ? ctrl_i.wr_data : value_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  // probe rotation and counting of smaller and equal entries
  always_comb begin
    trav_d  = trav_q;
    below_d = below_q;
    same_d  = same_q;
    if (ctrl_i.load) begin
      trav_d  = value_q;
      below_d = '0;
      same_d  = '0;
    end else if (ctrl_i.shift) begin
      trav_d  = trav_i;
      below_d = below_q + CNT_W'(trav_q < value_q);
      same_d  = same_q + CNT_W'(trav_q == value_q);
    end
  end

  // rank window check: below <= k < below + same
  assign upper = {1'b0, below_q} + {1'b0, same_q};
  assign hit   = (below_q <= ctrl_i.rank) && ({1'b0, ctrl_i.rank} < upper);

  always_comb begin
    pick_d = pick_q;
    if (ctrl_i.pick) begin
      pick_d = hit ? value_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    trav_q  <= trav_d;
    below_q <= below_d;
    same_q  <= same_d;
    pick_q  <= pick_d;
  end

  assign trav_o  = trav_q;
  assign value_o = value_q;
  assign pick_o  = pick_q;

endmodule

// File: hw/rtl/swm_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swm_row
// Ring of window cells with write decode, read mux and selection merge.
// ----------------------------------------------------------------------------
module swm_row import swm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic              wr_en_i,
  input  logic [IDX_W-1:0]  wr_idx_i,
  input  logic [IDX_W-1:0]  rd_idx_i,
  output logic [DATA_W-1:0] rd_data_o,
  output logic [DATA_W-1:0] median_o
);

  logic [DATA_W-1:0] trav [WINDOW];
  logic [DATA_W-1:0] val  [WINDOW];
  logic [DATA_W-1:0] pick [WINDOW];

  // cells, probe passed from each cell to the next around the ring
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic we;
    assign we = wr_en_i && (wr_idx_i == IDX_W'(i));

    swm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .wr_en_i (we),
      .trav_i  (trav[(i + WINDOW - 1) % WINDOW]),
      .trav_o  (trav[i]),
      .value_o (val[i]),
      .pick_o  (pick[i])
    );
  end

  // oldest entry read for pop
  assign rd_data_o = val[rd_idx_i];

  // every qualifying cell holds the same value, others hold zero
  always_comb begin
    median_o = '0;
    for (int i = 0; i < WINDOW; i++) begin
      median_o = median_o | pick[i];
    end
  end

endmodule
